FILE: design/qmcf_pkg.sv
// Package: word types and constants for the quadratic map cycle finder.
package qmcf_pkg;

  localparam int unsigned ValueBits = 32;

  typedef logic [ValueBits-1:0] value_t;

  typedef struct packed {
    value_t modulus;
    value_t mult_coef;
    value_t add_const;
  } qmcf_in_t;

  typedef struct packed {
    value_t tail_length;
    value_t cycle_length;
    value_t off_cycle_count;
  } qmcf_out_t;

endpackage

FILE: design/quadratic_map_cycle_finder.sv
// Floyd cycle finder for x -> (a*x*x + b) mod n with a bit-serial modular multiplier.
// The input word is accepted, then a and b are reduced mod n on the shared multiplier; each
// phase-one round takes 3 map steps + 1 compare, each tail step 2 steps + 1 compare plus one
// final compare, each cycle element 1 step + 1 compare; then the result word waits until taken.
// Throughput: one word at a time; the shared unit does one multiplier bit per cycle.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle with no result pending.
module quadratic_map_cycle_finder
  import qmcf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  qmcf_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output qmcf_out_t out_data_o
);

  localparam int unsigned CntBits = $clog2(ValueBits);
  localparam logic [CntBits-1:0] CntLast = CntBits'(ValueBits - 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_RED_A, ST_RED_B,
    ST_P1_S, ST_P1_F1, ST_P1_F2, ST_P1_CMP,
    ST_P2_CMP, ST_P2_S, ST_P2_F,
    ST_P3_F, ST_P3_CMP, ST_DONE
  } state_e;

  typedef enum logic [1:0] {SUB_MUL1, SUB_MUL2, SUB_ADD} sub_e;

  state_e state_q, state_d;
  sub_e   sub_q, sub_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  value_t n_q, n_d, a_q, a_d, b_q, b_d;
  value_t acc_q, acc_d, mcand_q, mcand_d, mult_q, mult_d, x_q, x_d;
  value_t slow_q, slow_d, fast_q, fast_d, mu_q, mu_d, lam_q, lam_d;
  qmcf_out_t out_q, out_d;

  // Shared unit: acc = (2*acc + bit*mcand) mod n, one multiplier bit per cycle
  logic [ValueBits+1:0] sum, n1, n2;
  value_t mul_res;
  logic   mul_last;
  logic [ValueBits:0] add_sum;
  value_t add_res;
  logic   step_done;
  logic   start;
  value_t start_v;
  value_t one_mod;

  always_comb begin
    n1  = {2'b00, n_q};
    n2  = {1'b0, n_q, 1'b0};
    sum = {1'b0, acc_q, 1'b0} + (mult_q[ValueBits-1] ? {2'b00, mcand_q} : '0);
    if (sum >= n2) begin
      mul_res = ValueBits'(sum - n2);
    end else if (sum >= n1) begin
      mul_res = ValueBits'(sum - n1);
    end else begin
      mul_res = ValueBits'(sum);
    end
    mul_last = (cnt_q == CntLast);
    // final add of b, both operands below n
    add_sum = {1'b0, acc_q} + {1'b0, b_q};
    add_res = (add_sum >= {1'b0, n_q}) ? ValueBits'(add_sum - {1'b0, n_q})
                                        : ValueBits'(add_sum);
    step_done = (sub_q == SUB_ADD);
    one_mod = (n_q == value_t'(1)) ? '0 : value_t'(1);
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    sub_d   = sub_q;
    cnt_d   = cnt_q;
    n_d     = n_q;
    a_d     = a_q;
    b_d     = b_q;
    acc_d   = acc_q;
    mcand_d = mcand_q;
    mult_d  = mult_q;
    x_d     = x_q;
    slow_d  = slow_q;
    fast_d  = fast_q;
    mu_d    = mu_q;
    lam_d   = lam_q;
    out_d   = out_q;
    start   = 1'b0;
    start_v = '0;

    // advance the multiplier in any state that runs it
    if (state_q == ST_RED_A || state_q == ST_RED_B ||
        ((state_q == ST_P1_S || state_q == ST_P1_F1 || state_q == ST_P1_F2 ||
          state_q == ST_P2_S || state_q == ST_P2_F || state_q == ST_P3_F) &&
         sub_q != SUB_ADD)) begin
      acc_d  = mul_res;
      mult_d = mult_q << 1;
      cnt_d  = cnt_q + 1'b1;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.modulus == '0) begin
            out_d.tail_length     = '0;
            out_d.cycle_length    = value_t'(1);
            out_d.off_cycle_count = '0;
            state_d = ST_DONE;
          end else begin
            n_d     = in_data_i.modulus;
            b_d     = in_data_i.add_const;
            mcand_d = (in_data_i.modulus == value_t'(1)) ? '0 : value_t'(1);
            mult_d  = in_data_i.mult_coef;
            acc_d   = '0;
            cnt_d   = '0;
            state_d = ST_RED_A;
          end
        end
      end
      ST_RED_A: begin
        if (mul_last) begin
          a_d     = mul_res;
          mcand_d = one_mod;
          mult_d  = b_q;
          acc_d   = '0;
          cnt_d   = '0;
          state_d = ST_RED_B;
        end
      end
      ST_RED_B: begin
        if (mul_last) begin
          b_d     = mul_res;
          slow_d  = '0;
          fast_d  = '0;
          start   = 1'b1;
          start_v = '0;
          state_d = ST_P1_S;
        end
      end
      ST_P1_S: begin
        if (step_done) begin
          slow_d  = add_res;
          start   = 1'b1;
          start_v = fast_q;
          state_d = ST_P1_F1;
        end
      end
      ST_P1_F1: begin
        if (step_done) begin
          start   = 1'b1;
          start_v = add_res;
          state_d = ST_P1_F2;
        end
      end
      ST_P1_F2: begin
        if (step_done) begin
          fast_d  = add_res;
          state_d = ST_P1_CMP;
        end
      end
      ST_P1_CMP: begin
        if (slow_q == fast_q) begin
          fast_d  = '0;
          mu_d    = '0;
          state_d = ST_P2_CMP;
        end else begin
          start   = 1'b1;
          start_v = slow_q;
          state_d = ST_P1_S;
        end
      end
      ST_P2_CMP: begin
        start   = 1'b1;
        start_v = slow_q;
        if (slow_q == fast_q) begin
          lam_d   = value_t'(1);
          state_d = ST_P3_F;
        end else begin
          state_d = ST_P2_S;
        end
      end
      ST_P2_S: begin
        if (step_done) begin
          slow_d  = add_res;
          start   = 1'b1;
          start_v = fast_q;
          state_d = ST_P2_F;
        end
      end
      ST_P2_F: begin
        if (step_done) begin
          fast_d  = add_res;
          mu_d    = mu_q + 1'b1;
          state_d = ST_P2_CMP;
        end
      end
      ST_P3_F: begin
        if (step_done) begin
          fast_d  = add_res;
          state_d = ST_P3_CMP;
        end
      end
      ST_P3_CMP: begin
        if (slow_q == fast_q) begin
          out_d.tail_length     = mu_q;
          out_d.cycle_length    = lam_q;
          out_d.off_cycle_count = n_q - lam_q;
          state_d = ST_DONE;
        end else begin
          lam_d   = lam_q + 1'b1;
          start   = 1'b1;
          start_v = fast_q;
          state_d = ST_P3_F;
        end
      end
      ST_DONE: begin
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // map-step sub-sequence: t = a*x, t = t*x, then add b
    if (!start && state_q != ST_RED_A && state_q != ST_RED_B && mul_last &&
        sub_q != SUB_ADD) begin
      if (sub_q == SUB_MUL1) begin
        mcand_d = mul_res;
        mult_d  = x_q;
        acc_d   = '0;
        cnt_d   = '0;
        sub_d   = SUB_MUL2;
      end else begin
        sub_d = SUB_ADD;
      end
    end

    // launch a new map step on start_v
    if (start) begin
      x_d     = start_v;
      mult_d  = start_v;
      mcand_d = a_q;
      acc_d   = '0;
      cnt_d   = '0;
      sub_d   = SUB_MUL1;
    end
  end

  // Sequencer state, sub-step and bit counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sub_q   <= SUB_MUL1;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      sub_q   <= sub_d;
      cnt_q   <= cnt_d;
    end
  end

  // Datapath words
  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    a_q     <= a_d;
    b_q     <= b_d;
    acc_q   <= acc_d;
    mcand_q <= mcand_d;
    mult_q  <= mult_d;
    x_q     <= x_d;
    slow_q  <= slow_d;
    fast_q  <= fast_d;
    mu_q    <= mu_d;
    lam_q   <= lam_d;
    out_q   <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_DONE);
  assign out_data_o  = out_q;

endmodule

FILE: tb/testbench.sv
// Testbench for the quadratic map cycle finder: predicted Floyd results checked word by word.
`timescale 1ns / 100ps

module testbench;
  import qmcf_pkg::*;

  localparam int unsigned WatchdogLimit = 200000;
  localparam int unsigned DrainCycles   = 400;
  localparam int unsigned HoldCycles    = 3000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  qmcf_in_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  qmcf_out_t out_data_o;

  qmcf_out_t cycle_results_q[$];
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        hold_on = 1'b0;
  int unsigned quiet_cycles = 0;

  quadratic_map_cycle_finder DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // One iteration of x -> (a*x*x + b) mod n, operands already below n
  function automatic longint unsigned map_step(longint unsigned x, longint unsigned n,
                                               longint unsigned a, longint unsigned b);
    longint unsigned t;
    t = (a * x) % n;
    t = (t * x) % n;
    return (t + b) % n;
  endfunction

  // Tail length, cycle length and off-cycle count via tortoise and hare
  function automatic qmcf_out_t floyd_result(qmcf_in_t w);
    longint unsigned n, a, b, slow, fast, mu, lam;
    qmcf_out_t r;
    n = w.modulus;
    if (n == 0) begin
      r.tail_length = '0;
      r.cycle_length = value_t'(1);
      r.off_cycle_count = '0;
      return r;
    end
    a = w.mult_coef % n;
    b = w.add_const % n;
    slow = map_step(0, n, a, b);
    fast = map_step(slow, n, a, b);
    while (slow != fast) begin
      slow = map_step(slow, n, a, b);
      fast = map_step(map_step(fast, n, a, b), n, a, b);
    end
    mu = 0;
    fast = 0;
    while (slow != fast) begin
      slow = map_step(slow, n, a, b);
      fast = map_step(fast, n, a, b);
      mu++;
    end
    lam = 1;
    fast = map_step(slow, n, a, b);
    while (slow != fast) begin
      fast = map_step(fast, n, a, b);
      lam++;
    end
    r.tail_length = mu[ValueBits-1:0];
    r.cycle_length = lam[ValueBits-1:0];
    r.off_cycle_count = value_t'(n - lam);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input value_t got, input value_t want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // Offer one word, idling first at random; valid stays high if the next word follows
  task automatic send_word(input qmcf_in_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    cycle_results_q = {cycle_results_q, floyd_result(w)};
  endtask

  task automatic send_map(input value_t n, input value_t a, input value_t b);
    qmcf_in_t w;
    w.modulus = n;
    w.mult_coef = a;
    w.add_const = b;
    send_word(w);
  endtask

  // Mostly small moduli; large ones only with maps that settle at once
  function automatic qmcf_in_t random_word();
    qmcf_in_t w;
    int unsigned pick;
    pick = $urandom_range(99);
    w.mult_coef = $urandom;
    w.add_const = $urandom;
    if (pick < 75) begin
      w.modulus = $urandom_range(12, 1);
    end else if (pick < 85) begin
      w.modulus = $urandom_range(40, 13);
    end else begin
      w.modulus = $urandom | 32'h1;
      if (pick < 92) w.add_const = '0;
      else w.mult_coef = '0;
    end
    return w;
  endfunction

  task automatic wait_drained();
    while (cycle_results_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_map(32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_map(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
    send_map(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
    send_map(32'hFFFF_FFFF, 32'd0, 32'd5);
    send_map(32'hFFFF_FFFE, 32'd0, 32'hFFFF_FFFF);
    send_map(32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
    send_map(32'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_map(32'd7, 32'd10, 32'd9);
    send_map(32'd32, 32'd1, 32'd1);
    send_map(32'd40, 32'd3, 32'd7);
    send_map(32'd13, 32'd0, 32'd0);
    send_map(32'd11, 32'hFFFF_FFFF, 32'h0000_0000);
    in_valid_i <= 1'b0;
    wait_drained();
  endtask

  task automatic test_random(input int unsigned count);
    repeat (count) send_word(random_word());
    in_valid_i <= 1'b0;
    wait_drained();
  endtask

  // Receiver holds off while words keep coming, so the input stalls
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fork
      begin
        hold_on = 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_on = 1'b0;
      end
    join_none
    repeat (4) send_map($urandom_range(6, 1), $urandom, $urandom);
    in_valid_i <= 1'b0;
    wait_drained();
  endtask

  // Receiver stall: held during a long hold, else random idling
  always @(posedge clk_i) begin
    if (hold_on) begin
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Result check and watchdog
  always @(posedge clk_i) begin
    qmcf_out_t want;
    if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("FAILURE");
      $finish;
    end
    if (out_valid_o && !out_stall_i) begin
      if (cycle_results_q.size() == 0) begin
        report_mismatch("unexpected word, tail_length", out_data_o.tail_length, '0);
      end else begin
        want = cycle_results_q.pop_front();
        if (out_data_o.tail_length !== want.tail_length)
          report_mismatch("tail_length", out_data_o.tail_length, want.tail_length);
        if (out_data_o.cycle_length !== want.cycle_length)
          report_mismatch("cycle_length", out_data_o.cycle_length, want.cycle_length);
        if (out_data_o.off_cycle_count !== want.off_cycle_count)
          report_mismatch("off_cycle_count", out_data_o.off_cycle_count,
                          want.off_cycle_count);
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 38;
    recv_idle_pct = 72;
    test_directed();
    test_random(34);
    send_idle_pct = 72;
    recv_idle_pct = 38;
    test_random(33);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(33);
    test_backpressure();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && cycle_results_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
